FILE: sv/tcp_mss_option_clamp_core_assert.svh
// Assertion macros for the checker file tmoc_checker.sv.
`ifndef TCP_MSS_OPTION_CLAMP_CORE_ASSERT_SVH
`define TCP_MSS_OPTION_CLAMP_CORE_ASSERT_SVH

// Same-cycle implication.
`define TMOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tmoc assertion failed");

// Next-cycle implication.
`define TMOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tmoc assertion failed");

`endif

FILE: sv/tmoc_pkg.sv
`timescale 1ns / 1ps

package tmoc_pkg;

    localparam int unsigned CNT_W       = 6;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 56;
    localparam int unsigned PADDR_W     = 3;

    localparam logic [7:0] KIND_END = 8'h00;
    localparam logic [7:0] KIND_NOP = 8'h01;
    localparam logic [7:0] KIND_MSS = 8'h02;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [15:0] MSS_CLAMP_RESET = 16'd1410;
    localparam logic        REG_MSS_CLAMP   = 1'b0;

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [POS_W-1:0] kind_position;
        logic [POS_W-1:0] length_position;
        logic [POS_W-1:0] value_position;
        logic             mss_kind_seen;
        logic             walk_stopped;
        logic             low_byte_pending;
        logic [15:0]      captured_mss;
        logic [CNT_W-1:0] captured_offset;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        byte_count:       '0,
        kind_position:    9'd0,
        length_position:  9'd1,
        value_position:   9'd2,
        mss_kind_seen:    1'b0,
        walk_stopped:     1'b0,
        low_byte_pending: 1'b0,
        captured_mss:     16'd0,
        captured_offset:  '0
    };

    typedef struct packed {
        logic             mss_found;
        logic [15:0]      old_mss;
        logic [CNT_W-1:0] mss_pos;
    } parse_out_t;

    // Packed MSB first; mss_found lands in bit 0 of tdata.
    typedef struct packed {
        logic [15:0]      new_checksum;
        logic [15:0]      new_mss;
        logic             rewrite;
        logic [CNT_W-1:0] mss_pos;
        logic [15:0]      old_mss;
        logic             mss_found;
    } result_t;

    // Ones-complement 16-bit add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

FILE: sv/tmoc_parser.sv
`timescale 1ns / 1ps

module tmoc_parser #(
    parameter int unsigned MAX_OPTION_BYTES = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_fire,
    input  logic [7:0]          option_byte,
    input  logic                first_byte,
    input  logic                last_byte,
    output tmoc_pkg::parse_out_t parse_out
);

    localparam logic [tmoc_pkg::CNT_W-1:0] MAX_B = tmoc_pkg::CNT_W'(MAX_OPTION_BYTES);

    tmoc_pkg::parse_state_t state_reg;
    tmoc_pkg::parse_state_t walk_state;
    tmoc_pkg::parse_state_t state_next;

    always_comb begin
        tmoc_pkg::parse_state_t  cur;
        logic [tmoc_pkg::POS_W-1:0] idx;
        logic [tmoc_pkg::POS_W-1:0] len_new;
        cur     = first_byte ? tmoc_pkg::PARSE_RESET : state_reg;
        idx     = {{(tmoc_pkg::POS_W - tmoc_pkg::CNT_W){1'b0}}, cur.byte_count};
        len_new = cur.length_position + {1'b0, option_byte};
        walk_state = cur;
        if (!cur.walk_stopped) begin
            if (cur.low_byte_pending) begin
                walk_state.captured_mss     = {cur.captured_mss[15:8], option_byte};
                walk_state.low_byte_pending = 1'b0;
                walk_state.walk_stopped     = 1'b1;
            end else if (cur.byte_count < MAX_B) begin
                if (idx == cur.kind_position) begin
                    if (option_byte == tmoc_pkg::KIND_END) begin
                        walk_state.walk_stopped = 1'b1;
                    end else if (option_byte == tmoc_pkg::KIND_NOP) begin
                        walk_state.kind_position   = cur.kind_position + 9'd1;
                        walk_state.length_position = cur.kind_position + 9'd2;
                    end else if (option_byte == tmoc_pkg::KIND_MSS) begin
                        walk_state.mss_kind_seen   = 1'b1;
                        walk_state.length_position = cur.kind_position + 9'd1;
                    end else if (cur.mss_kind_seen) begin
                        walk_state.mss_kind_seen = 1'b0;
                        walk_state.walk_stopped  = 1'b1;
                    end else begin
                        walk_state.length_position = cur.kind_position + 9'd1;
                    end
                end else if (idx == cur.length_position) begin
                    walk_state.value_position  = cur.length_position + 9'd1;
                    walk_state.length_position = len_new;
                    walk_state.kind_position   = len_new - 9'd1;
                end else if (idx >= cur.value_position) begin
                    if (cur.mss_kind_seen && cur.captured_offset == '0) begin
                        walk_state.captured_offset  = cur.byte_count;
                        walk_state.captured_mss     = {option_byte, 8'h00};
                        walk_state.low_byte_pending = 1'b1;
                    end
                end
            end
        end
        if (cur.byte_count != tmoc_pkg::CNT_MAX) begin
            walk_state.byte_count = cur.byte_count + 1'b1;
        end
        state_next = last_byte ? tmoc_pkg::PARSE_RESET : walk_state;
    end

    always_comb begin
        parse_out.mss_found = (walk_state.captured_offset != '0) && !walk_state.low_byte_pending;
        parse_out.old_mss   = parse_out.mss_found ? walk_state.captured_mss : 16'd0;
        parse_out.mss_pos   = parse_out.mss_found ? walk_state.captured_offset : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tmoc_pkg::PARSE_RESET;
        end else if (byte_fire) begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/tcp_mss_option_clamp_core.sv
`timescale 1ns / 1ps
// Each result is registered into the output or skid register when s_tlast is accepted.
// Throughput: one option byte per cycle while s_tready is high; a two-entry output buffer
// (output register plus skid register) keeps s_tready high while one result waits on m_tready.
// Reset (aresetn low, synchronous): parse state cleared, output buffer emptied,
// mss_clamp returns to 1410.
module tcp_mss_option_clamp_core #(
    parameter int unsigned MAX_OPTION_BYTES = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmoc_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // option byte stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tmoc_pkg::IN_TDATA_W-1:0]     s_tdata,  // option_byte[7:0], old_checksum[23:8]
    input  logic                                s_tuser,  // first_byte
    input  logic                                s_tlast,  // last_byte
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tmoc_pkg::OUT_TDATA_W-1:0]    m_tdata   // mss_found[0], old_mss[16:1],
                                                          // mss_pos[22:17], rewrite[23],
                                                          // new_mss[39:24], new_checksum[55:40]
);

    logic [15:0]          mss_clamp_reg;
    tmoc_pkg::parse_out_t parse_out;
    tmoc_pkg::result_t    result;
    tmoc_pkg::result_t    out_reg;
    tmoc_pkg::result_t    skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 s_fire;
    logic                 push;
    logic                 pop;
    logic [15:0]          sum_first;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tmoc_pkg::REG_MSS_CLAMP) ? {16'd0, mss_clamp_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mss_clamp_reg <= tmoc_pkg::MSS_CLAMP_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == tmoc_pkg::REG_MSS_CLAMP) begin
            mss_clamp_reg <= pwdata[15:0];
        end
    end

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign push     = s_fire && s_tlast;
    assign pop      = m_tvalid && m_tready;

    tmoc_parser #(
        .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_fire  (s_fire),
        .option_byte(s_tdata[7:0]),
        .first_byte (s_tuser),
        .last_byte  (s_tlast),
        .parse_out  (parse_out)
    );

    // RFC 1624 eqn. 3 incremental update
    always_comb begin
        result.mss_found  = parse_out.mss_found;
        result.old_mss    = parse_out.old_mss;
        result.mss_pos    = parse_out.mss_pos;
        result.rewrite    = parse_out.mss_found && (parse_out.old_mss >= mss_clamp_reg);
        result.new_mss    = result.rewrite ? mss_clamp_reg : parse_out.old_mss;
        sum_first         = tmoc_pkg::ones_add(~s_tdata[23:8], ~parse_out.old_mss);
        result.new_checksum = result.rewrite
                            ? ~tmoc_pkg::ones_add(sum_first, result.new_mss)
                            : s_tdata[23:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else if (!push) begin
                    out_valid_reg <= 1'b0;
                end
            end else if (push && out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else if (push) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (push && (pop || !out_valid_reg)) begin
            out_reg <= result;
        end
        if (push && out_valid_reg && !pop) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: sv/tmoc_checker.sv
`timescale 1ns / 1ps
`include "tcp_mss_option_clamp_core_assert.svh"

module tmoc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tmoc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    `TMOC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TMOC_ASSERT_IMP(a_rewrite_needs_mss, aclk, aresetn, m_tvalid && m_tdata[23], m_tdata[0])
    `TMOC_ASSERT_IMP(a_no_mss_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[23:1] == 23'd0)
    `TMOC_ASSERT_IMP(a_keep_mss, aclk, aresetn, m_tvalid && !m_tdata[23], m_tdata[39:24] == m_tdata[16:1])
    `TMOC_ASSERT_IMP(a_offset_set, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[22:17] != 6'd0)

endmodule

bind tcp_mss_option_clamp_core tmoc_checker u_tmoc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

FILE: tb/tcp_mss_option_clamp_checker.sv
`timescale 1ns / 1ps

module tcp_mss_option_clamp_checker #(
    parameter int MAX_OPTION_BYTES = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmoc_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    input  logic                                pready,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [tmoc_pkg::IN_TDATA_W-1:0]     s_tdata,  // option_byte[7:0], old_checksum[23:8]
    input  logic                                s_tuser,  // first_byte
    input  logic                                s_tlast,  // last_byte
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [tmoc_pkg::OUT_TDATA_W-1:0]    m_tdata,  // mss_found[0], old_mss[16:1],
                                                          // mss_pos[22:17], rewrite[23],
                                                          // new_mss[39:24], new_checksum[55:40]
    output int                                  error_count,
    output int                                  pending_count,
    output int                                  results_checked,
    output int                                  rewrites_seen
);
    import tmoc_pkg::*;

    localparam logic [PADDR_W-1:0] CLAMP_ADDR = PADDR_W'(4 * REG_MSS_CLAMP);

    logic [15:0]      clamp_value;
    logic [5:0]       seg_count;
    logic [8:0]       kind_pos;
    logic [8:0]       len_pos;
    logic [8:0]       val_pos;
    logic             mss_kind;
    logic             stopped;
    logic             low_pending;
    logic [15:0]      mss_word;
    logic [5:0]       mss_at;
    result_t          expected_results[$];

    function automatic logic [15:0] oc_sum(input logic [15:0] a, input logic [15:0] b);
        int unsigned t;
        t = 32'(a) + 32'(b);
        t = (t & 32'hFFFF) + (t >> 16);
        return t[15:0];
    endfunction

    task automatic restart_segment();
        seg_count   = '0;
        kind_pos    = 9'd0;
        len_pos     = 9'd1;
        val_pos     = 9'd2;
        mss_kind    = 1'b0;
        stopped     = 1'b0;
        low_pending = 1'b0;
        mss_word    = '0;
        mss_at      = '0;
    endtask

    task automatic walk_option_byte(input logic [7:0] b);
        if (!stopped) begin
            if (low_pending) begin
                mss_word[7:0] = b;
                low_pending   = 1'b0;
                stopped       = 1'b1;
            end else if (int'(seg_count) < MAX_OPTION_BYTES) begin
                if (seg_count == kind_pos) begin
                    if (b == KIND_END) begin
                        stopped = 1'b1;
                    end else begin
                        if (b == KIND_NOP) begin
                            kind_pos = kind_pos + 9'd1;
                        end else if (b == KIND_MSS) begin
                            mss_kind = 1'b1;
                        end else if (mss_kind) begin
                            // unknown kind after an MSS kind ends the walk
                            mss_kind = 1'b0;
                            stopped  = 1'b1;
                        end
                        if (!stopped)
                            len_pos = kind_pos + 9'd1;
                    end
                end else if (seg_count == len_pos) begin
                    val_pos  = len_pos + 9'd1;
                    len_pos  = len_pos + {1'b0, b};
                    kind_pos = len_pos - 9'd1;
                end else if (seg_count >= val_pos) begin
                    if (mss_kind && mss_at == '0) begin
                        mss_at      = seg_count;
                        mss_word    = {b, 8'h00};
                        low_pending = 1'b1;
                    end
                end
            end
        end
        if (seg_count != 6'h3F)
            seg_count = seg_count + 6'd1;
    endtask

    task automatic close_segment(input logic [15:0] csum);
        result_t r;
        logic    found;
        found          = (mss_at != '0) && !low_pending;
        r.mss_found    = found;
        r.old_mss      = found ? mss_word : 16'd0;
        r.mss_pos      = found ? mss_at : '0;
        r.rewrite      = found && (r.old_mss >= clamp_value);
        r.new_mss      = r.rewrite ? clamp_value : r.old_mss;
        r.new_checksum = r.rewrite ? ~oc_sum(oc_sum(~csum, ~r.old_mss), r.new_mss) : csum;
        expected_results.push_back(r);
        restart_segment();
    endtask

    task automatic compare_field(input string label, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            clamp_value = MSS_CLAMP_RESET;
            restart_segment();
            expected_results.delete();
            error_count     = 0;
            results_checked = 0;
            rewrites_seen   = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == CLAMP_ADDR)
                clamp_value = pwdata[15:0];
            if (s_tvalid && s_tready) begin
                if (s_tuser)
                    restart_segment();
                walk_option_byte(s_tdata[7:0]);
                if (s_tlast)
                    close_segment(s_tdata[23:8]);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, actual 0x%0h",
                             $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("mss_found", 16'(want.mss_found), 16'(got.mss_found));
                    compare_field("old_mss", want.old_mss, got.old_mss);
                    compare_field("mss_pos", 16'(want.mss_pos), 16'(got.mss_pos));
                    compare_field("rewrite", 16'(want.rewrite), 16'(got.rewrite));
                    compare_field("new_mss", want.new_mss, got.new_mss);
                    compare_field("new_checksum", want.new_checksum, got.new_checksum);
                    results_checked++;
                    if (want.rewrite)
                        rewrites_seen++;
                end
            end
        end
        pending_count <= expected_results.size();
    end

endmodule

FILE: tb/tb_tcp_mss_option_clamp_core.sv
`timescale 1ns / 1ps

module tb_tcp_mss_option_clamp_core;
    import tmoc_pkg::*;

    localparam int BYTE_LIMIT  = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 180;
    localparam logic [PADDR_W-1:0] CLAMP_ADDR = PADDR_W'(4 * REG_MSS_CLAMP);

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // option_byte[7:0], old_checksum[23:8]
    logic                   s_tuser;   // first_byte
    logic                   s_tlast;   // last_byte
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // mss_found[0], old_mss[16:1], mss_pos[22:17],
                                       // rewrite[23], new_mss[39:24], new_checksum[55:40]

    int          error_count;
    int          pending_count;
    int          results_checked;
    int          rewrites_seen;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          segments_sent = 0;
    int          settings_used = 1;
    int          hold_reqs = 0;
    int          holds_done = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    logic [15:0] clamp_now;
    logic [7:0]  seg_bytes[$];

    tcp_mss_option_clamp_core #(
        .MAX_OPTION_BYTES(BYTE_LIMIT)
    ) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tcp_mss_option_clamp_checker #(
        .MAX_OPTION_BYTES(BYTE_LIMIT)
    ) clamp_check (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .error_count(error_count), .pending_count(pending_count),
        .results_checked(results_checked), .rewrites_seen(rewrites_seen)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when requested
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_reqs != holds_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end
            stall = rx_idle ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    task automatic send_option_byte(input logic [7:0] b, input logic first, input logic last,
                                    input logic [15:0] csum);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {csum, b};
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_segment(input int first_at, input logic [15:0] csum);
        int n;
        n = seg_bytes.size();
        for (int i = 0; i < n; i++)
            send_option_byte(seg_bytes[i], i == first_at, i == n - 1,
                             (i == n - 1) ? csum : 16'($urandom));
        segments_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_clamp(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CLAMP_ADDR;
        pwdata  <= {16'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        clamp_now = v;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_checksum();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // values around the clamp hit both sides of the compare
    function automatic logic [15:0] pick_mss();
        case ($urandom_range(0, 6))
            0:       return clamp_now - 16'd1;
            1:       return clamp_now;
            2:       return clamp_now + 16'd1;
            3:       return 16'h0000;
            4:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_mss_option();
        logic [15:0] v;
        v = pick_mss();
        seg_bytes.push_back(KIND_MSS);
        seg_bytes.push_back(8'd4);
        seg_bytes.push_back(v[15:8]);
        seg_bytes.push_back(v[7:0]);
    endtask

    task automatic push_filler();
        int len;
        if ($urandom_range(0, 2) == 0) begin
            seg_bytes.push_back(KIND_NOP);
        end else begin
            len = $urandom_range(2, 8);
            seg_bytes.push_back(8'($urandom_range(3, 255)));
            seg_bytes.push_back(8'(len));
            repeat (len - 2) seg_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_well_formed();
        seg_bytes.delete();
        if ($urandom_range(0, 5) == 0) begin
            // NOP run pushes the MSS value up against the byte limit
            repeat ($urandom_range(30, 40)) seg_bytes.push_back(KIND_NOP);
            push_mss_option();
        end else begin
            repeat ($urandom_range(0, 3)) push_filler();
            if ($urandom_range(0, 7) != 0)
                push_mss_option();
            repeat ($urandom_range(0, 2)) push_filler();
            if ($urandom_range(0, 2) == 0) begin
                seg_bytes.push_back(KIND_END);
                repeat ($urandom_range(0, 3)) seg_bytes.push_back(8'($urandom));
            end
        end
        if (seg_bytes.size() == 0)
            seg_bytes.push_back(KIND_NOP);
    endtask

    task automatic build_noise();
        int n;
        seg_bytes.delete();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 70) : $urandom_range(1, 20);
        repeat (n) seg_bytes.push_back(8'($urandom));
    endtask

    task automatic send_random_segment();
        int pick;
        int cut;
        int first_at;
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
            build_well_formed();
        end else if (pick < 16) begin
            build_well_formed();
            cut = $urandom_range(1, seg_bytes.size());
            while (seg_bytes.size() > cut) void'(seg_bytes.pop_back());
        end else begin
            build_noise();
        end
        first_at = $urandom_range(0, 1) ? 0 : -1;
        if (seg_bytes.size() > 1 && $urandom_range(0, 11) == 0)
            first_at = $urandom_range(1, seg_bytes.size() - 1);
        send_segment(first_at, pick_checksum());
        if ($urandom_range(0, 14) == 0)
            tx_idle = !tx_idle;
        if ($urandom_range(0, 14) == 0)
            rx_idle = !rx_idle;
    endtask

    initial begin
        logic [15:0] v;
        int          start;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        clamp_now = MSS_CLAMP_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset clamp value
        seg_bytes = '{8'h02, 8'h04, 8'h05, 8'hB4};
        send_segment(0, 16'h0000);
        seg_bytes = '{8'h01, 8'h01, 8'h02, 8'h04, 8'h05, 8'h82};  // equal to clamp
        send_segment(-1, 16'hFFFF);
        seg_bytes = '{8'h00};
        send_segment(0, 16'hFFFF);
        seg_bytes = '{8'h02, 8'h04, 8'h05};                       // cut after high byte
        send_segment(-1, 16'h1234);
        seg_bytes = '{8'h02, 8'h02, 8'h08, 8'h05};                // unknown kind after MSS
        send_segment(-1, 16'hABCD);
        seg_bytes = '{8'h03, 8'h03, 8'h07, 8'h02, 8'h04, 8'hFF, 8'hFF};
        send_segment(0, 16'h0001);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       v = 16'd1;
                1:       v = 16'hFFFF;
                2:       v = 16'd0;
                3:       v = 16'd536;
                4:       v = 16'd1460;
                7:       v = MSS_CLAMP_RESET;
                default: v = 16'($urandom_range(1, 65535));
            endcase
            write_clamp(v);
            tx_idle = (p % 3 != 2);
            rx_idle = (p % 2 == 0);
            start = bytes_sent;
            if (p == 4) begin
                // back-to-back MSS segments against a stalled result side
                hold_reqs++;
                tx_idle = 1'b0;
                repeat (40) begin
                    seg_bytes.delete();
                    push_mss_option();
                    send_segment(0, pick_checksum());
                end
            end
            while (bytes_sent - start < PHASE_BYTES)
                send_random_segment();
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("Sent %0d option bytes in %0d segments under %0d clamp settings.",
                 bytes_sent, segments_sent, settings_used);
        $display("Checked %0d results, %0d of them MSS rewrites; one long result-side stall.",
                 results_checked, rewrites_seen);
        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
